FILE: sv/bat_pkg.sv
package bat_pkg;

	// Storage geometry
	localparam int unsigned CAPACITY = 1024;
	localparam int unsigned ADDR_W   = 10;
	localparam int unsigned COUNT_W  = 11;
	localparam int unsigned DATA_W   = 32;
	localparam int unsigned REQ_W    = 3;
	localparam int unsigned STAT_W   = 2;

	// Stream word widths (fields packed from bit 0, padded to bytes)
	localparam int unsigned IN_BITS  = REQ_W + DATA_W + ADDR_W;
	localparam int unsigned OUT_BITS = STAT_W + ADDR_W + DATA_W + COUNT_W;
	localparam int unsigned IN_W     = ((IN_BITS + 7) / 8) * 8;
	localparam int unsigned OUT_W    = ((OUT_BITS + 7) / 8) * 8;

	typedef logic [ADDR_W-1:0]  addr_t;
	typedef logic [COUNT_W-1:0] count_t;
	typedef logic [DATA_W-1:0]  data_t;
	typedef logic [REQ_W-1:0]   req_t;
	typedef logic [STAT_W-1:0]  status_t;

	// Request kinds
	localparam req_t REQ_PUSH    = 3'd0;
	localparam req_t REQ_REM_POS = 3'd1;
	localparam req_t REQ_REM_VAL = 3'd2;
	localparam req_t REQ_FIND    = 3'd3;
	localparam req_t REQ_READ    = 3'd4;
	localparam req_t REQ_CLEAR   = 3'd5;

	// Result status codes
	localparam status_t STAT_OK        = 2'd0;
	localparam status_t STAT_FULL      = 2'd1;
	localparam status_t STAT_BAD_POS   = 2'd2;
	localparam status_t STAT_NOT_FOUND = 2'd3;

endpackage

FILE: sv/bounded_array_table.sv
// Channel  Dir  tdata fields (low bit first)                          Handshake
// s_       in   req_type[2:0] value[34:3] position[44:35] pad[47:45]   s_tvalid/s_tready
// m_       out  status[1:0] index[11:2] data[43:12] count[54:44] pad    m_tvalid/m_tready
//
// Push, clear, bad position and unknown kinds are answered from idle; read at waits
// on a registered memory read. Find scans from the top entry down to the last match.
// Remove shifts each entry above the removed one down by one place, using the single
// element memory, which takes one read and one write per cycle.
// Reset clears the fill count and output valid; memory contents are not cleared.
// A new word is taken only in idle, and only while the output register is empty or draining.
module bounded_array_table (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	// req_type[2:0], value[34:3], position[44:35], zero pad
	input  logic [bat_pkg::IN_W-1:0]  s_tdata,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	// status[1:0], index[11:2], data[43:12], count[54:44], zero pad
	output logic [bat_pkg::OUT_W-1:0] m_tdata
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_SHIFT = 2'd2;
	localparam logic [1:0] ST_READ  = 2'd3;

	localparam bat_pkg::count_t CAP_CNT = bat_pkg::COUNT_W'(bat_pkg::CAPACITY);

	// Input word unpack
	bat_pkg::req_t  in_req;
	bat_pkg::data_t in_value;
	bat_pkg::addr_t in_pos;
	assign in_req   = s_tdata[bat_pkg::REQ_W-1:0];
	assign in_value = s_tdata[bat_pkg::REQ_W +: bat_pkg::DATA_W];
	assign in_pos   = s_tdata[bat_pkg::REQ_W + bat_pkg::DATA_W +: bat_pkg::ADDR_W];

	// Control and request registers
	logic [1:0]      state_q, state_d;
	bat_pkg::count_t cnt_q, cnt_d;
	bat_pkg::addr_t  ptr_q, ptr_d;
	bat_pkg::addr_t  idx_q, idx_d;
	bat_pkg::data_t  val_q;
	bat_pkg::req_t   req_q;

	// Element memory, one write and one registered read per cycle
	bat_pkg::data_t mem [bat_pkg::CAPACITY];
	bat_pkg::data_t rd_data_q;
	logic           mem_we, mem_re;
	bat_pkg::addr_t mem_waddr, mem_raddr;
	bat_pkg::data_t mem_wdata;

	// Output register
	logic             m_tvalid_q;
	bat_pkg::status_t status_q, res_status;
	bat_pkg::addr_t   index_q, res_index;
	bat_pkg::data_t   data_q, res_data;
	bat_pkg::count_t  count_q;
	logic             res_load;

	logic accept;
	assign s_tready = (state_q == ST_IDLE) && (!m_tvalid_q || m_tready);
	assign accept   = s_tvalid && s_tready;

	// Sequencer: next state, memory port controls, result load
	always_comb begin
		state_d    = state_q;
		cnt_d      = cnt_q;
		ptr_d      = ptr_q;
		idx_d      = idx_q;
		mem_we     = 1'b0;
		mem_waddr  = '0;
		mem_wdata  = '0;
		mem_re     = 1'b0;
		mem_raddr  = '0;
		res_load   = 1'b0;
		res_status = bat_pkg::STAT_OK;
		res_index  = '0;
		res_data   = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (in_req)
						bat_pkg::REQ_PUSH: begin
							res_load = 1'b1;
							if (cnt_q == CAP_CNT) begin
								res_status = bat_pkg::STAT_FULL;
							end else begin
								mem_we    = 1'b1;
								mem_waddr = cnt_q[bat_pkg::ADDR_W-1:0];
								mem_wdata = in_value;
								res_index = cnt_q[bat_pkg::ADDR_W-1:0];
								cnt_d     = cnt_q + 1'b1;
							end
						end
						bat_pkg::REQ_REM_POS: begin
							if ({1'b0, in_pos} >= cnt_q) begin
								res_load   = 1'b1;
								res_status = bat_pkg::STAT_BAD_POS;
							end else if ({1'b0, in_pos} + 1'b1 == cnt_q) begin
								// last entry: nothing to shift
								res_load  = 1'b1;
								res_index = in_pos;
								cnt_d     = cnt_q - 1'b1;
							end else begin
								idx_d     = in_pos;
								mem_re    = 1'b1;
								mem_raddr = in_pos + 1'b1;
								ptr_d     = in_pos + 1'b1;
								state_d   = ST_SHIFT;
							end
						end
						bat_pkg::REQ_REM_VAL, bat_pkg::REQ_FIND: begin
							if (cnt_q == '0) begin
								res_load   = 1'b1;
								res_status = bat_pkg::STAT_NOT_FOUND;
							end else begin
								// scan downward so the first hit is the last match
								mem_re    = 1'b1;
								mem_raddr = bat_pkg::ADDR_W'(cnt_q - 1'b1);
								ptr_d     = bat_pkg::ADDR_W'(cnt_q - 1'b1);
								state_d   = ST_SCAN;
							end
						end
						bat_pkg::REQ_READ: begin
							if ({1'b0, in_pos} >= cnt_q) begin
								res_load   = 1'b1;
								res_status = bat_pkg::STAT_BAD_POS;
							end else begin
								mem_re    = 1'b1;
								mem_raddr = in_pos;
								state_d   = ST_READ;
							end
						end
						bat_pkg::REQ_CLEAR: begin
							res_load = 1'b1;
							cnt_d    = '0;
						end
						default: begin
							res_load = 1'b1;
						end
					endcase
				end
			end
			ST_SCAN: begin
				if (rd_data_q == val_q) begin
					idx_d = ptr_q;
					if (req_q == bat_pkg::REQ_FIND) begin
						res_load  = 1'b1;
						res_index = ptr_q;
						state_d   = ST_IDLE;
					end else if ({1'b0, ptr_q} + 1'b1 == cnt_q) begin
						res_load  = 1'b1;
						res_index = ptr_q;
						cnt_d     = cnt_q - 1'b1;
						state_d   = ST_IDLE;
					end else begin
						mem_re    = 1'b1;
						mem_raddr = ptr_q + 1'b1;
						ptr_d     = ptr_q + 1'b1;
						state_d   = ST_SHIFT;
					end
				end else if (ptr_q == '0) begin
					res_load   = 1'b1;
					res_status = bat_pkg::STAT_NOT_FOUND;
					state_d    = ST_IDLE;
				end else begin
					mem_re    = 1'b1;
					mem_raddr = ptr_q - 1'b1;
					ptr_d     = ptr_q - 1'b1;
				end
			end
			ST_SHIFT: begin
				// entry at ptr moves down by one
				mem_we    = 1'b1;
				mem_waddr = ptr_q - 1'b1;
				mem_wdata = rd_data_q;
				if ({1'b0, ptr_q} + 1'b1 < cnt_q) begin
					mem_re    = 1'b1;
					mem_raddr = ptr_q + 1'b1;
					ptr_d     = ptr_q + 1'b1;
				end else begin
					res_load  = 1'b1;
					res_index = idx_q;
					cnt_d     = cnt_q - 1'b1;
					state_d   = ST_IDLE;
				end
			end
			ST_READ: begin
				res_load = 1'b1;
				res_data = rd_data_q;
				state_d  = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Memory port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_data_q <= mem[mem_raddr];
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (res_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Request and result payload
	always_ff @(posedge clk) begin
		ptr_q <= ptr_d;
		idx_q <= idx_d;
		if (accept) begin
			val_q <= in_value;
			req_q <= in_req;
		end
		if (res_load) begin
			status_q <= res_status;
			index_q  <= res_index;
			data_q   <= res_data;
			count_q  <= cnt_d;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = bat_pkg::OUT_W'({count_q, data_q, index_q, status_q});

`ifndef NO_ASSERTIONS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CAP_CNT)
		else $error("fill count above capacity");

	a_ptr_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN || state_q == ST_SHIFT) |-> ({1'b0, ptr_q} < cnt_q))
		else $error("walk pointer beyond stored entries");

	a_shift_ptr_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SHIFT) |-> (ptr_q != '0))
		else $error("shift would write below entry zero");

	a_shift_done_dec: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SHIFT && res_load) |=> (cnt_q == $past(cnt_q) - 1'b1))
		else $error("remove did not decrement count");

	a_no_load_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(res_load && m_tvalid_q) |-> m_tready)
		else $error("result overwrote an untaken word");
`endif

endmodule
